>>> rtl/color_sensor_calibrate_classify_core_defines.svh
// ----------------------------------------------------------------------------
// Color sensor core assertion macros
// Shared concurrent assertion forms used by the core's modules.
// ----------------------------------------------------------------------------
`ifndef COLOR_SENSOR_CALIBRATE_CLASSIFY_CORE_DEFINES_SVH
`define COLOR_SENSOR_CALIBRATE_CLASSIFY_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define CSCC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define CSCC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/cscc_pkg.sv
// ----------------------------------------------------------------------------
// Color sensor core package
// Types, constants and helper functions shared by the core's modules.
// ----------------------------------------------------------------------------
package cscc_pkg;

   localparam int RAW_WIDTH  = 11;
   // a * 100 fits in RAW_WIDTH + 7 bits
   localparam int QUO_WIDTH  = RAW_WIDTH + 7;
   localparam int PROD_WIDTH = QUO_WIDTH + 32;
   localparam int CNT_WIDTH  = $clog2(QUO_WIDTH + 1);

   localparam logic [5:0]  CAL_BYTES  = 6'd54;
   localparam logic [5:0]  DATA_BYTES = 6'd52;
   localparam logic [5:0]  GAIN_BYTES = 6'd48;
   localparam logic [15:0] CRC_START  = 16'h5AA5;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   localparam logic [10:0] MIN_BLANK_RESET     = 11'd214;
   localparam logic [15:0] BLANK_DIVISOR_RESET = 16'd79;

   // Request commands
   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_SAMPLE  = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   // Register addresses (word index)
   localparam logic REG_MIN_BLANK     = 1'b0;
   localparam logic REG_BLANK_DIVISOR = 1'b1;

   // Color codes
   localparam logic [2:0] CODE_BLACK  = 3'd0;
   localparam logic [2:0] CODE_BLUE   = 3'd1;
   localparam logic [2:0] CODE_GREEN  = 3'd2;
   localparam logic [2:0] CODE_YELLOW = 3'd3;
   localparam logic [2:0] CODE_RED    = 3'd4;
   localparam logic [2:0] CODE_WHITE  = 3'd5;

   localparam logic [1:0] CHAN_AMBIENT = 2'd3;

   typedef struct packed {
      logic [1:0]           command;
      logic [7:0]           cal_byte;
      logic [RAW_WIDTH-1:0] raw_blank;
      logic [RAW_WIDTH-1:0] raw_red;
      logic [RAW_WIDTH-1:0] raw_green;
      logic [RAW_WIDTH-1:0] raw_blue;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  color_code;
      logic [15:0] cal_red;
      logic [15:0] cal_green;
      logic [15:0] cal_blue;
      logic [15:0] cal_ambient;
      logic [15:0] crc_running;
      logic [15:0] crc_received;
      logic        stream_done;
      logic        crc_match;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COLOR,
      ST_DIVIDE,
      ST_AMBIENT,
      ST_CLASSIFY,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mul_color;
      logic       div_step;
      logic       mul_ambient;
      logic       classify;
      logic       respond;
      logic [1:0] chan;
   } ctl_type;

   // Reflected CRC-16 over one byte, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i, input logic [7:0] v_i);
      logic [15:0] c;
      logic [7:0]  v;
      c = crc_i;
      v = v_i;
      for (int i = 0; i < 8; i++) begin
         if ((v[0] ^ c[0]) == 1'b1) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
         v = v >> 1;
      end
      return c;
   endfunction

   // Firmware decision tree on calibrated values
   function automatic logic [2:0] classify(input logic [15:0] r_i, input logic [15:0] g_i,
                                           input logic [15:0] b_i, input logic [15:0] a_i);
      logic [21:0] r;
      logic [21:0] g;
      logic [21:0] b;
      logic [21:0] a;
      logic [2:0]  code;
      r = 22'(r_i);
      g = 22'(g_i);
      b = 22'(b_i);
      a = 22'(a_i);
      if (r > b && r > g) begin
         if (r < 22'd65 || (a < 22'd40 && r < 22'd110)) code = CODE_BLACK;
         else if ((b >> 2) + (b >> 3) + b < g && (g << 1) > r) code = CODE_YELLOW;
         else if ((g << 1) - (g >> 2) < r) code = CODE_RED;
         else if (b < 22'd70 || g < 22'd70 || (a < 22'd140 && r < 22'd140)) code = CODE_BLACK;
         else code = CODE_WHITE;
      end else if (g > b) begin
         if (g < 22'd40 || (a < 22'd30 && g < 22'd70)) code = CODE_BLACK;
         else if ((b << 1) < r) code = CODE_YELLOW;
         else if (r + (r >> 2) < g || b + (b >> 2) < g) code = CODE_GREEN;
         else if (r < 22'd70 || b < 22'd70 || (a < 22'd140 && g < 22'd140)) code = CODE_BLACK;
         else code = CODE_WHITE;
      end else begin
         // x * 48 = (x << 5) + (x << 4); x * 58 = (x << 5) + (x << 4) + (x << 3) + (x << 1)
         if (b < 22'd48 || (a < 22'd25 && b < 22'd85)) code = CODE_BLACK;
         else if (((((r << 5) + (r << 4)) >> 5) < b && (((g << 5) + (g << 4)) >> 5) < b)
                  || ((((r << 5) + (r << 4) + (r << 3) + (r << 1)) >> 5) < b)
                  || ((((g << 5) + (g << 4) + (g << 3) + (g << 1)) >> 5) < b))
            code = CODE_BLUE;
         else if (r < 22'd60 || g < 22'd60 || (a < 22'd110 && b < 22'd120)) code = CODE_BLACK;
         else if (r + (r >> 3) < b || g + (g >> 3) < b) code = CODE_BLUE;
         else code = CODE_WHITE;
      end
      return code;
   endfunction

   // Saturate a shifted product to 16 bits
   function automatic logic [15:0] sat16(input logic [PROD_WIDTH-17:0] v);
      logic [15:0] s;
      if (v > (PROD_WIDTH-16)'(16'hFFFF)) s = 16'hFFFF;
      else s = v[15:0];
      return s;
   endfunction

endpackage

>>> rtl/cscc_ctrl.sv
// ----------------------------------------------------------------------------
// Color sensor core controller
// Sequences color products, ambient division, classification and response.
// ----------------------------------------------------------------------------
`include "color_sensor_calibrate_classify_core_defines.svh"

module cscc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        command,
   output logic              busy,
   output cscc_pkg::ctl_type ctl
);
   import cscc_pkg::*;

   state_type              state_ff, state_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   // Next state and step counter
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (start) begin
               if (command == CMD_SAMPLE) state_in = ST_COLOR;
               else state_in = ST_RESPOND;
            end
         end
         ST_COLOR: begin
            if (count_ff == CNT_WIDTH'(2)) begin
               count_in = '0;
               state_in = ST_DIVIDE;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (count_ff == CNT_WIDTH'(QUO_WIDTH - 1)) begin
               count_in = '0;
               state_in = ST_AMBIENT;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_AMBIENT:  state_in = ST_CLASSIFY;
         ST_CLASSIFY: state_in = ST_RESPOND;
         ST_RESPOND:  state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      ctl = '0;
      ctl.chan = count_ff[1:0];
      case (state_ff)
         ST_IDLE:     ctl.load = start;
         ST_COLOR:    ctl.mul_color = 1'b1;
         ST_DIVIDE:   ctl.div_step = 1'b1;
         ST_AMBIENT:  ctl.mul_ambient = 1'b1;
         ST_CLASSIFY: ctl.classify = 1'b1;
         ST_RESPOND:  ctl.respond = 1'b1;
         default:     ctl = '0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   `CSCC_ASSERT(a_respond_once, ctl.respond |=> !ctl.respond && state_ff == ST_IDLE, "response not single")
   `CSCC_ASSERT(a_load_busy, ctl.load |=> busy, "accepted request did not raise busy")
   `CSCC_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == ST_IDLE && count_ff == '0, "reset not idle")

endmodule

>>> rtl/cscc_datapath.sv
// ----------------------------------------------------------------------------
// Color sensor core datapath
// Calibration stream capture, CRC, gain products, divider and classifier.
// ----------------------------------------------------------------------------
module cscc_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  cscc_pkg::ctl_type         ctl,
   input  cscc_pkg::req_payload_type req,
   input  logic                      cfg_write,
   input  logic                      cfg_addr,
   input  logic [31:0]               cfg_wdata,
   output logic [31:0]               cfg_rdata,
   output cscc_pkg::rsp_payload_type rsp
);
   import cscc_pkg::*;

   logic [31:0]           gain_ff [12];
   logic [15:0]           limit_ff [2];
   logic [15:0]           crc_ff, crc_in;
   logic [5:0]            count_ff, count_in;
   logic [31:0]           word_ff, word_in;
   logic [15:0]           rxcrc_ff, rxcrc_in;
   logic                  gain_we;
   logic                  limit_we;
   logic [31:0]           word_new;
   logic [10:0]           min_blank_ff;
   logic [15:0]           blank_div_ff;

   logic [RAW_WIDTH-1:0]  blank_ff;
   logic [RAW_WIDTH-1:0]  raw_ff [3];
   logic [1:0]            row_ff, row_in;
   logic [15:0]           cv_ff [4];
   logic [2:0]            code_ff;

   logic [QUO_WIDTH-1:0]  quo_ff;
   logic [15:0]           rem_ff;
   logic [15:0]           divisor_ff;
   logic [16:0]           rem_shift;
   logic                  rem_ge;
   logic [QUO_WIDTH-1:0]  amb_base;
   logic [QUO_WIDTH-1:0]  blank_ext;
   logic [QUO_WIDTH-1:0]  min_ext;

   logic [RAW_WIDTH-1:0]  diff;
   logic [QUO_WIDTH-1:0]  mul_a;
   logic [31:0]           mul_b;
   logic [PROD_WIDTH-1:0] product;

   // Calibration byte capture
   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      word_in  = word_ff;
      rxcrc_in = rxcrc_ff;
      gain_we  = 1'b0;
      limit_we = 1'b0;
      word_new = word_ff;
      if (count_ff < CAL_BYTES) begin
         count_in = count_ff + 1'b1;
         if (count_ff < DATA_BYTES) begin
            crc_in = crc_byte(crc_ff, req.cal_byte);
            if (count_ff < GAIN_BYTES) begin
               word_new = word_ff | ({24'b0, req.cal_byte} << {count_ff[1:0], 3'b000});
               gain_we  = (count_ff[1:0] == 2'd3);
            end else begin
               word_new = word_ff | ({24'b0, req.cal_byte} << {count_ff[0], 3'b000});
               limit_we = count_ff[0];
            end
            word_in = (gain_we || limit_we) ? 32'b0 : word_new;
         end else begin
            rxcrc_in = {rxcrc_ff[7:0], req.cal_byte};
         end
      end
   end

   // Stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_START;
         count_ff <= '0;
         word_ff  <= '0;
         rxcrc_ff <= '0;
      end else if (ctl.load && req.command == CMD_BYTE) begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         word_ff  <= word_in;
         rxcrc_ff <= rxcrc_in;
      end else if (ctl.load && req.command == CMD_RESTART) begin
         crc_ff   <= CRC_START;
         count_ff <= '0;
         word_ff  <= '0;
         rxcrc_ff <= '0;
      end
   end

   // Gain and limit tables
   always_ff @(posedge clock) begin
      if (ctl.load && req.command == CMD_BYTE && gain_we) begin
         gain_ff[count_ff[5:2]] <= word_new;
      end
      if (ctl.load && req.command == CMD_BYTE && limit_we) begin
         limit_ff[count_ff[1]] <= word_new[15:0];
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_blank_ff <= MIN_BLANK_RESET;
         blank_div_ff <= BLANK_DIVISOR_RESET;
      end else if (cfg_write) begin
         if (cfg_addr == REG_MIN_BLANK) min_blank_ff <= cfg_wdata[10:0];
         else blank_div_ff <= cfg_wdata[15:0];
      end
   end

   assign cfg_rdata = (cfg_addr == REG_BLANK_DIVISOR) ? {16'b0, blank_div_ff}
                                                      : {21'b0, min_blank_ff};

   // Gain row from blank level against the limits
   always_comb begin
      if (16'(req.raw_blank) < limit_ff[1]) row_in = 2'd2;
      else if (16'(req.raw_blank) < limit_ff[0]) row_in = 2'd1;
      else row_in = 2'd0;
   end

   // Ambient dividend: max(blank - min_blank, 0) * 100
   assign blank_ext = QUO_WIDTH'(req.raw_blank);
   assign min_ext   = QUO_WIDTH'(min_blank_ff);
   always_comb begin
      logic [QUO_WIDTH-1:0] a;
      a = (blank_ext > min_ext) ? blank_ext - min_ext : '0;
      amb_base = (a << 6) + (a << 5) + (a << 2);
   end

   // Restoring divider, one quotient bit per step
   assign rem_shift = {rem_ff, quo_ff[QUO_WIDTH-1]};
   assign rem_ge    = (rem_shift >= {1'b0, divisor_ff});

   // Shared multiplier operands
   always_comb begin
      diff  = (raw_ff[ctl.chan] > blank_ff) ? raw_ff[ctl.chan] - blank_ff : '0;
      mul_a = ctl.mul_ambient ? quo_ff : QUO_WIDTH'(diff);
      mul_b = gain_ff[ctl.mul_ambient ? {row_ff, CHAN_AMBIENT} : {row_ff, ctl.chan}];
   end
   assign product = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

   // Sample pipeline registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         blank_ff   <= req.raw_blank;
         raw_ff[0]  <= req.raw_red;
         raw_ff[1]  <= req.raw_green;
         raw_ff[2]  <= req.raw_blue;
         row_ff     <= row_in;
         quo_ff     <= amb_base;
         rem_ff     <= '0;
         divisor_ff <= (blank_div_ff == 16'd0) ? 16'd1 : blank_div_ff;
         if (req.command != CMD_SAMPLE) begin
            cv_ff[0] <= '0;
            cv_ff[1] <= '0;
            cv_ff[2] <= '0;
            cv_ff[3] <= '0;
            code_ff  <= CODE_BLACK;
         end
      end
      if (ctl.mul_color) begin
         cv_ff[ctl.chan] <= sat16(product[PROD_WIDTH-1:16]);
      end
      if (ctl.div_step) begin
         rem_ff <= rem_ge ? 16'(rem_shift - {1'b0, divisor_ff}) : rem_shift[15:0];
         quo_ff <= {quo_ff[QUO_WIDTH-2:0], rem_ge};
      end
      if (ctl.mul_ambient) begin
         cv_ff[CHAN_AMBIENT] <= sat16(product[PROD_WIDTH-1:16]);
      end
      if (ctl.classify) begin
         code_ff <= classify(cv_ff[0], cv_ff[1], cv_ff[2], cv_ff[3]);
      end
   end

   // Response fields
   always_comb begin
      rsp.color_code   = code_ff;
      rsp.cal_red      = cv_ff[0];
      rsp.cal_green    = cv_ff[1];
      rsp.cal_blue     = cv_ff[2];
      rsp.cal_ambient  = cv_ff[3];
      rsp.crc_running  = crc_ff;
      rsp.crc_received = rxcrc_ff;
      rsp.stream_done  = (count_ff >= CAL_BYTES);
      rsp.crc_match    = (count_ff >= CAL_BYTES) && (rxcrc_ff == crc_ff);
   end

endmodule

>>> rtl/color_sensor_calibrate_classify_core.sv
// ----------------------------------------------------------------------------
// Color sensor calibration and classification core
// Takes the sensor's calibration byte stream, checks its CRC, then scales raw
// samples with the selected gain row and classifies them into a color code.
//
// Request channel: a request is taken when start is high and busy is low.
// Command 0 feeds one calibration byte, 1 a color sample, 2 restarts the
// stream. Every request gives exactly one response, shown for one cycle
// with rsp_valid high; the receiver cannot stall it.
// Byte and restart requests answer in the cycle after acceptance.
// A sample runs the color products on the shared 32-bit gain multiplier,
// the restoring divider for the ambient value at one quotient bit per
// cycle, then the ambient product and classification. One request is in
// flight at a time; the next one is taken the cycle after the response.
// Configuration: APB-style writes to min_blank (0x0) and blank_divisor
// (0x4), done while busy is low.
// Reset: synchronous; restores the CRC seed and the register defaults and
// clears the stream count. Gain and limit tables hold until written.
// ----------------------------------------------------------------------------
module color_sensor_calibrate_classify_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  cscc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   output cscc_pkg::rsp_payload_type rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import cscc_pkg::*;

   ctl_type ctl;
   logic    cfg_write;

   // APB write at access phase, no wait states
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign rsp_valid = ctl.respond;

   cscc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_payload.command),
      .busy    (busy),
      .ctl     (ctl)
   );

   cscc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req       (req_payload),
      .cfg_write (cfg_write),
      .cfg_addr  (paddr[2]),
      .cfg_wdata (pwdata),
      .cfg_rdata (prdata),
      .rsp       (rsp_payload)
   );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color sensor core testbench
// Feeds calibration streams, restarts and color samples through the request
// channel, predicts each response in a scoreboard and compares every field.
// ----------------------------------------------------------------------------
import cscc_pkg::*;

class color_scoreboard;
   logic [31:0] gains [12];
   logic [15:0] limits [2];
   logic [15:0] crc_acc;
   logic [5:0]  count;
   logic [31:0] assembly;
   logic [15:0] crc_word;
   logic [10:0] min_blank;
   logic [15:0] divisor;
   rsp_payload_type pending [$];
   int errors;

   function void clear();
      crc_acc = CRC_START; count = 0; assembly = 0; crc_word = 0;
      min_blank = MIN_BLANK_RESET; divisor = BLANK_DIVISOR_RESET;
      errors = 0;
      foreach (gains[i]) gains[i] = 0;
      limits[0] = 0; limits[1] = 0;
   endfunction

   function logic [15:0] crc8(logic [15:0] c, logic [7:0] v);
      for (int i = 0; i < 8; i++) begin
         if (v[0] ^ c[0]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
         v = v >> 1;
      end
      return c;
   endfunction

   function logic [15:0] clamp(longint unsigned v);
      return v > 65535 ? 16'hFFFF : v[15:0];
   endfunction

   function logic [2:0] sort_color(int unsigned r, int unsigned g, int unsigned b,
                                   int unsigned a);
      if (r > b && r > g) begin
         if (r < 65 || (a < 40 && r < 110)) return CODE_BLACK;
         if ((b >> 2) + (b >> 3) + b < g && (g << 1) > r) return CODE_YELLOW;
         if ((g << 1) - (g >> 2) < r) return CODE_RED;
         if (b < 70 || g < 70 || (a < 140 && r < 140)) return CODE_BLACK;
         return CODE_WHITE;
      end else if (g > b) begin
         if (g < 40 || (a < 30 && g < 70)) return CODE_BLACK;
         if ((b << 1) < r) return CODE_YELLOW;
         if (r + (r >> 2) < g || b + (b >> 2) < g) return CODE_GREEN;
         if (r < 70 || b < 70 || (a < 140 && g < 140)) return CODE_BLACK;
         return CODE_WHITE;
      end
      if (b < 48 || (a < 25 && b < 85)) return CODE_BLACK;
      if ((((r * 48) >> 5) < b && ((g * 48) >> 5) < b) || ((r * 58) >> 5) < b
          || ((g * 58) >> 5) < b) return CODE_BLUE;
      if (r < 60 || g < 60 || (a < 110 && b < 120)) return CODE_BLACK;
      if (r + (r >> 3) < b || g + (g >> 3) < b) return CODE_BLUE;
      return CODE_WHITE;
   endfunction

   function void write_reg(logic idx, logic [31:0] v);
      if (idx == REG_MIN_BLANK) min_blank = v[10:0];
      else divisor = v[15:0];
   endfunction

   // Note an accepted request and queue its predicted response
   function void note_request(req_payload_type q);
      rsp_payload_type p;
      longint unsigned blank, a, d;
      longint unsigned raw [3];
      int row;
      logic [15:0] cv [4];
      p = '0;
      foreach (cv[i]) cv[i] = 0;
      if (q.command == CMD_BYTE && count < CAL_BYTES) begin
         if (count < DATA_BYTES) begin
            crc_acc = crc8(crc_acc, q.cal_byte);
            if (count < GAIN_BYTES) begin
               assembly |= 32'(q.cal_byte) << (8 * count[1:0]);
               if (count[1:0] == 2'd3) begin
                  gains[count >> 2] = assembly; assembly = 0;
               end
            end else begin
               assembly |= 32'(q.cal_byte) << (8 * count[0]);
               if (count[0]) begin
                  limits[(count - GAIN_BYTES) >> 1] = assembly[15:0]; assembly = 0;
               end
            end
         end else crc_word = {crc_word[7:0], q.cal_byte};
         count++;
      end else if (q.command == CMD_RESTART) begin
         crc_acc = CRC_START; count = 0; assembly = 0; crc_word = 0;
      end else if (q.command == CMD_SAMPLE) begin
         blank = q.raw_blank;
         raw[0] = q.raw_red; raw[1] = q.raw_green; raw[2] = q.raw_blue;
         row = blank < limits[1] ? 2 : (blank < limits[0] ? 1 : 0);
         for (int c = 0; c < 3; c++)
            if (raw[c] > blank) cv[c] = clamp(((raw[c] - blank) * gains[row*4+c]) >> 16);
         a = blank > min_blank ? blank - min_blank : 0;
         d = divisor != 0 ? divisor : 1;
         a = (a * 100) / d;
         cv[3] = clamp((a * gains[row*4+3]) >> 16);
         p.color_code = sort_color(cv[0], cv[1], cv[2], cv[3]);
      end
      p.cal_red = cv[0]; p.cal_green = cv[1]; p.cal_blue = cv[2]; p.cal_ambient = cv[3];
      p.crc_running = crc_acc;
      p.crc_received = crc_word;
      p.stream_done = count >= CAL_BYTES;
      p.crc_match = p.stream_done && crc_word == crc_acc;
      pending.push_back(p);
   endfunction

   function void report(string f, longint unsigned e, longint unsigned g);
      $error("%s mismatch: expected %0d actual %0d", f, e, g);
      errors++;
   endfunction

   // Compare one response against the oldest prediction
   function void check_response(rsp_payload_type g);
      rsp_payload_type e;
      if (pending.size() == 0) begin
         $error("response with no request outstanding");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (g.color_code !== e.color_code) report("color_code", e.color_code, g.color_code);
      if (g.cal_red !== e.cal_red) report("cal_red", e.cal_red, g.cal_red);
      if (g.cal_green !== e.cal_green) report("cal_green", e.cal_green, g.cal_green);
      if (g.cal_blue !== e.cal_blue) report("cal_blue", e.cal_blue, g.cal_blue);
      if (g.cal_ambient !== e.cal_ambient) report("cal_ambient", e.cal_ambient, g.cal_ambient);
      if (g.crc_running !== e.crc_running) report("crc_running", e.crc_running, g.crc_running);
      if (g.crc_received !== e.crc_received)
         report("crc_received", e.crc_received, g.crc_received);
      if (g.stream_done !== e.stream_done) report("stream_done", e.stream_done, g.stream_done);
      if (g.crc_match !== e.crc_match) report("crc_match", e.crc_match, g.crc_match);
   endfunction
endclass

module testbench;
   localparam int STALL_LIMIT = 5000;
   localparam int REQ_BITS    = $bits(req_payload_type);

   logic clock, reset, start, busy, rsp_valid, pready;
   logic psel, penable, pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   color_scoreboard board;
   int idle_cycles;

   color_sensor_calibrate_classify_core dut (
      .clock, .reset, .start, .busy, .req_payload, .rsp_valid, .rsp_payload,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // Note accepted requests and check responses at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_request(req_payload);
         if (rsp_valid) board.check_response(rsp_payload);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) @(negedge clock);
   endtask

   // Hold one request until it is taken
   task automatic send(req_payload_type q);
      start = 1'b1;
      req_payload = q;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start = 1'b0;
      gap();
   endtask

   task automatic send_byte(logic [7:0] b);
      req_payload_type q;
      q = req_payload_type'(REQ_BITS'({$urandom, $urandom}));
      q.command = CMD_BYTE; q.cal_byte = b;
      send(q);
   endtask

   task automatic send_sample(int unsigned bl, int unsigned r, int unsigned g, int unsigned b);
      req_payload_type q;
      q = req_payload_type'(REQ_BITS'({$urandom, $urandom}));
      q.command = CMD_SAMPLE;
      q.raw_blank = RAW_WIDTH'(bl); q.raw_red = RAW_WIDTH'(r);
      q.raw_green = RAW_WIDTH'(g); q.raw_blue = RAW_WIDTH'(b);
      send(q);
   endtask

   task automatic send_other(logic [1:0] cmd);
      req_payload_type q;
      q = req_payload_type'(REQ_BITS'({$urandom, $urandom}));
      q.command = cmd;
      send(q);
   endtask

   // Send a whole calibration stream; gains spread over small and huge values
   task automatic send_stream(bit good_crc, int gain_kind);
      logic [7:0] bytes [54];
      logic [31:0] w;
      logic [15:0] c;
      c = CRC_START;
      for (int i = 0; i < 12; i++) begin
         case (gain_kind)
            0: w = $urandom_range(1 << 14, 1 << 18);
            1: w = 32'hFFFF_FFFF;
            default: w = $urandom;
         endcase
         if ($urandom_range(0, 7) == 0) w = $urandom;
         for (int k = 0; k < 4; k++) bytes[i*4+k] = w[8*k +: 8];
      end
      w = $urandom_range(0, 2047);
      {bytes[49], bytes[48]} = w[15:0] + 16'($urandom_range(0, 600));
      {bytes[51], bytes[50]} = w[15:0];
      if ($urandom_range(0, 5) == 0) {bytes[51], bytes[50]} = 16'($urandom);
      for (int i = 0; i < 52; i++) c = board.crc8(c, bytes[i]);
      if (!good_crc) c = c ^ 16'($urandom_range(1, 65535));
      bytes[52] = c[15:8]; bytes[53] = c[7:0];
      for (int i = 0; i < 54; i++) send_byte(bytes[i]);
   endtask

   // Wait for all responses, then a settle pause, before register writes
   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] v);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = {idx, 2'b00}; pwdata = v;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      board.write_reg(idx, v);
   endtask

   task automatic random_samples(int n);
      int unsigned bl;
      for (int i = 0; i < n; i++) begin
         bl = $urandom_range(0, 2047);
         if ($urandom_range(0, 2) == 0) bl = $urandom_range(0, 300);
         case ($urandom_range(0, 4))
            0: send_sample(bl, $urandom_range(0, 2047), $urandom_range(0, 2047),
                           $urandom_range(0, 2047));
            default: send_sample(bl, bl + $urandom_range(0, 150), bl + $urandom_range(0, 150),
                                 bl + $urandom_range(0, 150));
         endcase
         if ($urandom_range(0, 30) == 0) send_byte(8'($urandom));
         if ($urandom_range(0, 60) == 0) send_other(CMD_UNUSED);
      end
   endtask

   initial begin
      logic [31:0] mb [4];
      logic [31:0] dv [4];
      mb = '{0, 2047, 214, 1000};
      dv = '{1, 65535, 0, 79};
      board = new();
      board.clear();
      reset = 1'b1; start = 1'b0; req_payload = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: full stream, extremes, restart, ignored bytes, unused command
      send_stream(1'b1, 0);
      send_byte(8'hFF);
      send_sample(0, 0, 0, 0);
      send_sample(2047, 2047, 2047, 2047);
      send_sample(0, 2047, 2047, 2047);
      send_sample(2047, 0, 0, 0);
      send_sample(300, 1500, 400, 300);
      send_sample(300, 500, 1200, 300);
      send_sample(300, 400, 400, 1300);
      send_sample(300, 1300, 1300, 300);
      send_other(CMD_UNUSED);
      send_other(CMD_RESTART);
      send_sample(1000, 1500, 1500, 1500);
      send_stream(1'b0, 1);
      send_sample(0, 2047, 1024, 5);
      send_sample(1, 2046, 2047, 2045);

      // Random phases over register settings, extremes included
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         csr_write(REG_MIN_BLANK, ph < 4 ? mb[ph] : $urandom_range(0, 2047));
         csr_write(REG_BLANK_DIVISOR, ph < 4 ? dv[ph] : $urandom_range(0, 65535));
         if ($urandom_range(0, 3) == 0) begin
            for (int k = 0; k < 20; k++) send_byte(8'($urandom));
            send_other(CMD_RESTART);
         end else if ($urandom_range(0, 2) == 0) send_other(CMD_RESTART);
         if (ph % 2 == 0) begin
            send_other(CMD_RESTART);
            send_stream($urandom_range(0, 3) != 0, ph % 3);
         end
         random_samples(110);
      end

      drain();
      repeat (50) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
